// File: src/tts_pkg.sv
// Shared types, melody constants and helper functions for the tone sequencer.
`timescale 1ns / 1ps
package tts_pkg;

	localparam int unsigned ROM_LEN = 49;
	localparam int unsigned POS_W = 6;
	localparam int unsigned FREQ_W = 10;
	localparam int unsigned DUR_W = 11;
	localparam int unsigned GAP_W = 6;
	localparam int unsigned TIME_W = 32;
	localparam logic [TIME_W-1:0] AUTO_PLAY_RESET = 32'd5000;

	localparam logic [FREQ_W-1:0] HZ_A4 = 10'd440;
	localparam logic [FREQ_W-1:0] HZ_B4 = 10'd494;
	localparam logic [FREQ_W-1:0] HZ_C5 = 10'd523;
	localparam logic [FREQ_W-1:0] HZ_D5 = 10'd587;
	localparam logic [FREQ_W-1:0] HZ_E5 = 10'd659;
	localparam logic [FREQ_W-1:0] HZ_FS5 = 10'd740;
	localparam logic [FREQ_W-1:0] HZ_G5 = 10'd784;

	localparam logic [DUR_W-1:0] LEN_EIGHTH = 11'd285;
	localparam logic [DUR_W-1:0] LEN_DOTTED = 11'd441;
	localparam logic [DUR_W-1:0] LEN_SIXTEENTH = 11'd129;
	localparam logic [DUR_W-1:0] LEN_QUARTER = 11'd590;
	localparam logic [DUR_W-1:0] LEN_HALF = 11'd1190;
	localparam logic [DUR_W-1:0] LEN_FINAL = 11'd1222;
	localparam logic [DUR_W-1:0] LEN_REST = 11'd312;

	localparam logic [GAP_W-1:0] GAP_SHORT = 6'd27;
	localparam logic [GAP_W-1:0] GAP_QUARTER = 6'd34;
	localparam logic [GAP_W-1:0] GAP_LONG = 6'd58;
	localparam logic [GAP_W-1:0] GAP_NONE = 6'd0;

	typedef struct packed {
		logic [FREQ_W-1:0] hz;
		logic [DUR_W-1:0] len;
		logic [GAP_W-1:0] gap;
	} note_entry_t;

	localparam note_entry_t NOTE_EMPTY = '{hz: '0, len: '0, gap: '0};

	function automatic note_entry_t mk_note(input logic [FREQ_W-1:0] hz,
			input logic [DUR_W-1:0] len, input logic [GAP_W-1:0] gap);
		note_entry_t e;
		e.hz = hz;
		e.len = len;
		e.gap = gap;
		return e;
	endfunction

	function automatic note_entry_t eighth(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_EIGHTH, GAP_SHORT);
	endfunction

	function automatic note_entry_t dotted(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_DOTTED, GAP_SHORT);
	endfunction

	function automatic note_entry_t sixteenth(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_SIXTEENTH, GAP_SHORT);
	endfunction

	function automatic note_entry_t quarter(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_QUARTER, GAP_QUARTER);
	endfunction

	function automatic note_entry_t half(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_HALF, GAP_LONG);
	endfunction

	function automatic note_entry_t final_half(input logic [FREQ_W-1:0] hz);
		return mk_note(hz, LEN_FINAL, GAP_LONG);
	endfunction

	function automatic note_entry_t rest_note();
		return mk_note('0, LEN_REST, GAP_NONE);
	endfunction

	// time t is reached when the wrapped difference now - t is not negative
	function automatic logic time_reached(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] diff;
		diff = now - t;
		return ~diff[TIME_W-1];
	endfunction

endpackage

// File: src/tts_if.sv
// Tick and tone-command stream interfaces with valid/ready transfer.
`timescale 1ns / 1ps
interface tts_tick_if;
	logic valid;
	logic ready;
	logic [tts_pkg::TIME_W-1:0] now_ms;
	logic play_request;

	modport source (output valid, output now_ms, output play_request, input ready);
	modport sink (input valid, input now_ms, input play_request, output ready);
endinterface

interface tts_cmd_if;
	logic valid;
	logic ready;
	logic stop_tone;
	logic start_tone;
	logic [tts_pkg::FREQ_W-1:0] tone_freq_hz;
	logic [tts_pkg::DUR_W-1:0] tone_duration_ms;
	logic is_playing;

	modport source (output valid, output stop_tone, output start_tone,
		output tone_freq_hz, output tone_duration_ms, output is_playing, input ready);
	modport sink (input valid, input stop_tone, input start_tone,
		input tone_freq_hz, input tone_duration_ms, input is_playing, output ready);
endinterface

// File: src/tts_note_rom.sv
// Melody ROM: note frequency, length and gap for each position.
`timescale 1ns / 1ps
module tts_note_rom (
	input logic [tts_pkg::POS_W-1:0] pos,
	output tts_pkg::note_entry_t entry
);

	always_comb begin
		case (pos)
			6'd0: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd1: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd2: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd3: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd4: entry = tts_pkg::quarter(tts_pkg::HZ_E5);
			6'd5: entry = tts_pkg::rest_note();
			6'd6: entry = tts_pkg::eighth(tts_pkg::HZ_D5);
			6'd7: entry = tts_pkg::dotted(tts_pkg::HZ_C5);
			6'd8: entry = tts_pkg::sixteenth(tts_pkg::HZ_D5);
			6'd9: entry = tts_pkg::eighth(tts_pkg::HZ_C5);
			6'd10: entry = tts_pkg::eighth(tts_pkg::HZ_B4);
			6'd11: entry = tts_pkg::half(tts_pkg::HZ_A4);
			6'd12: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd13: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd14: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd15: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd16: entry = tts_pkg::quarter(tts_pkg::HZ_A4);
			6'd17: entry = tts_pkg::rest_note();
			6'd18: entry = tts_pkg::eighth(tts_pkg::HZ_G5);
			6'd19: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd20: entry = tts_pkg::eighth(tts_pkg::HZ_G5);
			6'd21: entry = tts_pkg::eighth(tts_pkg::HZ_G5);
			6'd22: entry = tts_pkg::eighth(tts_pkg::HZ_FS5);
			6'd23: entry = tts_pkg::half(tts_pkg::HZ_E5);
			6'd24: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd25: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd26: entry = tts_pkg::eighth(tts_pkg::HZ_A4);
			6'd27: entry = tts_pkg::eighth(tts_pkg::HZ_G5);
			6'd28: entry = tts_pkg::quarter(tts_pkg::HZ_E5);
			6'd29: entry = tts_pkg::rest_note();
			6'd30: entry = tts_pkg::eighth(tts_pkg::HZ_D5);
			6'd31: entry = tts_pkg::dotted(tts_pkg::HZ_C5);
			6'd32: entry = tts_pkg::sixteenth(tts_pkg::HZ_D5);
			6'd33: entry = tts_pkg::eighth(tts_pkg::HZ_C5);
			6'd34: entry = tts_pkg::eighth(tts_pkg::HZ_B4);
			6'd35: entry = tts_pkg::quarter(tts_pkg::HZ_A4);
			6'd36: entry = tts_pkg::quarter(tts_pkg::HZ_E5);
			6'd37: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd38: entry = tts_pkg::eighth(tts_pkg::HZ_C5);
			6'd39: entry = tts_pkg::eighth(tts_pkg::HZ_C5);
			6'd40: entry = tts_pkg::eighth(tts_pkg::HZ_B4);
			6'd41: entry = tts_pkg::quarter(tts_pkg::HZ_A4);
			6'd42: entry = tts_pkg::rest_note();
			6'd43: entry = tts_pkg::eighth(tts_pkg::HZ_E5);
			6'd44: entry = tts_pkg::dotted(tts_pkg::HZ_D5);
			6'd45: entry = tts_pkg::sixteenth(tts_pkg::HZ_C5);
			6'd46: entry = tts_pkg::eighth(tts_pkg::HZ_B4);
			6'd47: entry = tts_pkg::eighth(tts_pkg::HZ_G5);
			6'd48: entry = tts_pkg::final_half(tts_pkg::HZ_A4);
			default: entry = tts_pkg::NOTE_EMPTY;
		endcase
	end

endmodule

// File: src/timed_tone_sequencer.sv
// Top level of the timed tone sequencer: schedule state, note ROM and command register.
`timescale 1ns / 1ps
// Usage:
//   tick  - input stream; each transfer carries now_ms and play_request and yields
//           exactly one command on cmd.
//   cmd   - output stream with stop_tone, start_tone, tone_freq_hz, tone_duration_ms
//           and is_playing. When both are set, stop comes before start.
//   cfg_we / cfg_wdata - write auto_play_at_ms; write only while the block is idle.
// Each tick's command is registered and appears on cmd in the cycle after its transfer.
// Throughput: one tick per cycle unless cmd stalls; state update, one ROM read and
//   the 32-bit length-plus-gap add are done in a single step into the command register.
// tick.ready is high while the command register is empty or is being drained
//   in the same cycle, so a stalled receiver holds the command and stalls tick
//   after one buffered command.
// Reset (arst_n low): the command register empties, playback stops, the note
//   position and schedule clear, the auto-play flag clears and auto_play_at_ms
//   returns to 5000.
module timed_tone_sequencer #(
	parameter int unsigned NOTE_COUNT = 49
) (
	input logic clk,
	input logic arst_n,
	tts_tick_if.sink tick,
	tts_cmd_if.source cmd,
	input logic cfg_we,
	input logic [tts_pkg::TIME_W-1:0] cfg_wdata
);

	localparam logic [tts_pkg::POS_W-1:0] LAST_POS = tts_pkg::POS_W'(NOTE_COUNT);

	logic [tts_pkg::TIME_W-1:0] auto_at_q;
	logic [tts_pkg::POS_W-1:0] pos_q;
	logic [tts_pkg::TIME_W-1:0] next_time_q;
	logic playing_q;
	logic auto_done_q;

	logic cmd_valid_q;
	logic stop_q;
	logic start_q;
	logic [tts_pkg::FREQ_W-1:0] freq_q;
	logic [tts_pkg::DUR_W-1:0] dur_q;
	logic is_playing_q;

	logic accept;
	logic restart;
	logic [tts_pkg::POS_W-1:0] pos_eff;
	logic [tts_pkg::TIME_W-1:0] time_eff;
	logic playing_eff;
	logic due;
	logic at_end;
	logic is_rest;
	tts_pkg::note_entry_t entry;

	logic [tts_pkg::POS_W-1:0] pos_d;
	logic [tts_pkg::TIME_W-1:0] time_d;
	logic playing_d;
	logic stop_d;
	logic start_d;
	logic [tts_pkg::FREQ_W-1:0] freq_d;
	logic [tts_pkg::DUR_W-1:0] dur_d;

	assign tick.ready = ~cmd_valid_q | cmd.ready;
	assign accept = tick.valid & tick.ready;

	assign restart = tick.play_request |
		(~auto_done_q & tts_pkg::time_reached(tick.now_ms, auto_at_q));
	assign pos_eff = restart ? '0 : pos_q;
	assign time_eff = restart ? tick.now_ms : next_time_q;
	assign playing_eff = restart | playing_q;
	assign due = playing_eff & tts_pkg::time_reached(tick.now_ms, time_eff);
	assign at_end = pos_eff >= LAST_POS;

	tts_note_rom u_rom (
		.pos (pos_eff),
		.entry (entry)
	);

	assign is_rest = (entry.hz == '0) | (entry.len == '0);

	always_comb begin
		pos_d = pos_eff;
		time_d = time_eff;
		playing_d = playing_eff;
		stop_d = restart;
		start_d = 1'b0;
		freq_d = '0;
		dur_d = '0;
		if (due) begin
			if (at_end) begin
				playing_d = 1'b0;
				stop_d = 1'b1;
			end else begin
				pos_d = pos_eff + 1'b1;
				time_d = time_eff + tts_pkg::TIME_W'(entry.len) + tts_pkg::TIME_W'(entry.gap);
				if (is_rest) begin
					stop_d = 1'b1;
				end else begin
					start_d = 1'b1;
					freq_d = entry.hz;
					dur_d = entry.len;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_at_q <= tts_pkg::AUTO_PLAY_RESET;
		end else if (cfg_we) begin
			auto_at_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			next_time_q <= '0;
			playing_q <= 1'b0;
			auto_done_q <= 1'b0;
		end else if (accept) begin
			pos_q <= pos_d;
			next_time_q <= time_d;
			playing_q <= playing_d;
			auto_done_q <= auto_done_q | restart;
		end
	end

	// hold the command until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (tick.ready) begin
			cmd_valid_q <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stop_q <= stop_d;
			start_q <= start_d;
			freq_q <= freq_d;
			dur_q <= dur_d;
			is_playing_q <= playing_d;
		end
	end

	assign cmd.valid = cmd_valid_q;
	assign cmd.stop_tone = stop_q;
	assign cmd.start_tone = start_q;
	assign cmd.tone_freq_hz = freq_q;
	assign cmd.tone_duration_ms = dur_q;
	assign cmd.is_playing = is_playing_q;

`ifndef SYNTHESIS
	a_start_while_playing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.start_tone |-> cmd.is_playing)
		else $error("start_tone without is_playing");

	a_start_payload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.start_tone |-> cmd.tone_freq_hz != '0 && cmd.tone_duration_ms != '0)
		else $error("start_tone with empty note");

	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && !cmd.start_tone |-> cmd.tone_freq_hz == '0 && cmd.tone_duration_ms == '0)
		else $error("note fields set without start_tone");

	a_request_plays: assert property (@(posedge clk) disable iff (!arst_n)
		accept && tick.play_request |=> playing_q && auto_done_q && cmd.stop_tone)
		else $error("play request did not restart playback");

	a_end_stops: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(playing_q) |-> cmd.valid && cmd.stop_tone && !cmd.is_playing)
		else $error("playback ended without stop");
`endif

endmodule

// File: bench/timed_tone_sequencer_test.sv
// Testbench for the tone sequencer: random tick streams, built-in melody predictor, field checks.
`timescale 1ns / 1ps
module timed_tone_sequencer_test;

	localparam int unsigned TUNE_LEN = 49;

	typedef struct packed {
		logic [tts_pkg::TIME_W-1:0] now;
		logic req;
	} tick_item_t;

	typedef struct packed {
		logic stop;
		logic start;
		logic [tts_pkg::FREQ_W-1:0] hz;
		logic [tts_pkg::DUR_W-1:0] dur;
		logic playing;
	} tone_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic tick_valid_r = 1'b0;
	logic [tts_pkg::TIME_W-1:0] tick_now_r = '0;
	logic tick_req_r = 1'b0;
	logic cmd_ready_r = 1'b0;
	logic cfg_we_r = 1'b0;
	logic [tts_pkg::TIME_W-1:0] cfg_wdata_r = '0;

	tts_tick_if tick_bus();
	tts_cmd_if cmd_bus();

	assign tick_bus.valid = tick_valid_r;
	assign tick_bus.now_ms = tick_now_r;
	assign tick_bus.play_request = tick_req_r;
	assign cmd_bus.ready = cmd_ready_r;

	timed_tone_sequencer #(.NOTE_COUNT(TUNE_LEN)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.cmd(cmd_bus),
		.cfg_we(cfg_we_r),
		.cfg_wdata(cfg_wdata_r)
	);

	always #6 clk = ~clk;

	tick_item_t tick_feed[$];
	tone_cmd_t tone_cmds_due[$];
	int unsigned ticks_queued = 0;
	int unsigned cmds_seen = 0;
	int unsigned fail_count = 0;
	logic quiet = 1'b0;
	int unsigned hold_requests = 0;
	int unsigned holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned gap_left = 0;

	tts_pkg::note_entry_t melody_rom[tts_pkg::ROM_LEN];
	logic [tts_pkg::TIME_W-1:0] auto_play_at = tts_pkg::AUTO_PLAY_RESET;
	logic [tts_pkg::POS_W-1:0] note_idx = '0;
	logic [tts_pkg::TIME_W-1:0] note_due = '0;
	logic seq_active = 1'b0;
	logic auto_fired = 1'b0;

	initial begin : load_melody
		string shapes;
		string pitches;
		tts_pkg::note_entry_t n;
		shapes = "eeeeqredseeheeeeqreeeeeheeeeqredseeqqeeeeqredseef";
		pitches = "AEEEE-DCDCBAAAAAA-GEGGFEEAAGE-DCDCBAEECCBA-EDCBGA";
		for (int i = 0; i < tts_pkg::ROM_LEN; i++) begin
			case (shapes[i])
				"e": begin n.len = tts_pkg::LEN_EIGHTH; n.gap = tts_pkg::GAP_SHORT; end
				"d": begin n.len = tts_pkg::LEN_DOTTED; n.gap = tts_pkg::GAP_SHORT; end
				"s": begin n.len = tts_pkg::LEN_SIXTEENTH; n.gap = tts_pkg::GAP_SHORT; end
				"q": begin n.len = tts_pkg::LEN_QUARTER; n.gap = tts_pkg::GAP_QUARTER; end
				"h": begin n.len = tts_pkg::LEN_HALF; n.gap = tts_pkg::GAP_LONG; end
				"f": begin n.len = tts_pkg::LEN_FINAL; n.gap = tts_pkg::GAP_LONG; end
				default: begin n.len = tts_pkg::LEN_REST; n.gap = tts_pkg::GAP_NONE; end
			endcase
			case (pitches[i])
				"A": n.hz = tts_pkg::HZ_A4;
				"B": n.hz = tts_pkg::HZ_B4;
				"C": n.hz = tts_pkg::HZ_C5;
				"D": n.hz = tts_pkg::HZ_D5;
				"E": n.hz = tts_pkg::HZ_E5;
				"F": n.hz = tts_pkg::HZ_FS5;
				"G": n.hz = tts_pkg::HZ_G5;
				default: n.hz = '0;
			endcase
			melody_rom[i] = n;
		end
	end

	function automatic logic deadline_passed(input logic [tts_pkg::TIME_W-1:0] now,
			input logic [tts_pkg::TIME_W-1:0] t);
		logic [tts_pkg::TIME_W-1:0] delta;
		delta = now - t;
		return !delta[tts_pkg::TIME_W-1];
	endfunction

	task automatic predict_tone_cmd(input logic [tts_pkg::TIME_W-1:0] now, input logic req,
			output tone_cmd_t c);
		tts_pkg::note_entry_t n;
		c = '0;
		if (req || (!auto_fired && deadline_passed(now, auto_play_at))) begin
			auto_fired = 1'b1;
			c.stop = 1'b1;
			note_idx = '0;
			note_due = now;
			seq_active = 1'b1;
		end
		if (seq_active && deadline_passed(now, note_due)) begin
			if (note_idx >= TUNE_LEN) begin
				seq_active = 1'b0;
				c.stop = 1'b1;
			end else begin
				n = (note_idx < tts_pkg::ROM_LEN) ? melody_rom[note_idx] : tts_pkg::NOTE_EMPTY;
				note_idx = note_idx + 1'b1;
				if (n.hz == '0 || n.len == '0) begin
					c.stop = 1'b1;
				end else begin
					c.start = 1'b1;
					c.hz = n.hz;
					c.dur = n.len;
				end
				note_due = note_due + tts_pkg::TIME_W'(n.len) + tts_pkg::TIME_W'(n.gap);
			end
		end
		c.playing = seq_active;
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			tick_valid_r <= 1'b0;
			gap_left <= 0;
		end else if (!tick_valid_r || tick_bus.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				tick_valid_r <= 1'b0;
			end else if (tick_feed.size() != 0) begin
				tick_valid_r <= 1'b1;
				tick_now_r <= tick_feed[0].now;
				tick_req_r <= tick_feed[0].req;
				void'(tick_feed.pop_front());
				if (!quiet && $urandom_range(0, 5) == 0)
					gap_left <= $urandom_range(1, 13);
			end else begin
				tick_valid_r <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_ready_r <= 1'b0;
			hold_left <= 0;
		end else if (holds_served != hold_requests) begin
			holds_served <= holds_served + 1;
			hold_left <= 300;
			cmd_ready_r <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			cmd_ready_r <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			hold_left <= $urandom_range(0, 12);
			cmd_ready_r <= 1'b0;
		end else begin
			cmd_ready_r <= 1'b1;
		end
	end

	always @(posedge clk) begin : watch_cmds
		tone_cmd_t want;
		tone_cmd_t got;
		if (arst_n) begin
			if (cfg_we_r)
				auto_play_at = cfg_wdata_r;
			if (tick_bus.valid && tick_bus.ready) begin
				predict_tone_cmd(tick_bus.now_ms, tick_bus.play_request, want);
				tone_cmds_due.push_back(want);
			end
			if (cmd_bus.valid && cmd_bus.ready) begin
				got.stop = cmd_bus.stop_tone;
				got.start = cmd_bus.start_tone;
				got.hz = cmd_bus.tone_freq_hz;
				got.dur = cmd_bus.tone_duration_ms;
				got.playing = cmd_bus.is_playing;
				cmds_seen++;
				if (tone_cmds_due.size() == 0) begin
					$error("command transfer with no tick pending");
					fail_count++;
				end else begin
					want = tone_cmds_due.pop_front();
					check_field("stop_tone", want.stop, got.stop);
					check_field("start_tone", want.start, got.start);
					check_field("tone_freq_hz", want.hz, got.hz);
					check_field("tone_duration_ms", want.dur, got.dur);
					check_field("is_playing", want.playing, got.playing);
				end
			end
		end
	end

	task automatic queue_tick(input logic [tts_pkg::TIME_W-1:0] now, input logic req);
		tick_item_t item;
		item.now = now;
		item.req = req;
		tick_feed.push_back(item);
		ticks_queued++;
	endtask

	task automatic queue_melody_run(input int unsigned steps);
		logic [tts_pkg::TIME_W-1:0] t;
		int unsigned pick;
		if ($urandom_range(0, 3) == 0)
			t = 32'hFFFF_FFFF - $urandom_range(0, 20000);
		else
			t = $urandom;
		queue_tick(t, 1'b1);
		repeat (steps) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				t = t + $urandom_range(40, 600);
			else if (pick < 86)
				t = t + $urandom_range(600, 2500);
			else if (pick < 91)
				t = t - $urandom_range(1, 400);
			else if (pick < 94)
				t = $urandom;
			queue_tick(t, $urandom_range(0, 49) == 0);
		end
	endtask

	task automatic wait_drained();
		while (cmds_seen < ticks_queued)
			@(posedge clk);
	endtask

	task automatic write_auto_play(input logic [tts_pkg::TIME_W-1:0] value);
		wait_drained();
		repeat (3) @(posedge clk);
		cfg_we_r <= 1'b1;
		cfg_wdata_r <= value;
		@(posedge clk);
		cfg_we_r <= 1'b0;
	endtask

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [tts_pkg::TIME_W-1:0] setting;
		int unsigned target;
		int unsigned run_len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_tick(32'd0, 1'b0);
		queue_tick(32'h8000_1388, 1'b0);
		queue_tick(32'd4999, 1'b0);
		queue_tick(32'd5000, 1'b0);
		queue_tick(32'd5000, 1'b0);
		queue_tick(32'd5312, 1'b0);
		queue_tick(32'd5312, 1'b1);
		queue_tick(32'hFFFF_FFFF, 1'b1);
		queue_tick(32'h0000_0100, 1'b0);
		queue_tick(32'h0000_0137, 1'b0);
		repeat (4) queue_tick(32'h7FFF_FFFF, 1'b0);
		queue_tick(32'h8000_0000, 1'b0);
		queue_tick(32'hAAAA_AAAA, 1'b1);
		queue_tick(32'h5555_5555, 1'b0);
		queue_tick(32'hAAAA_AAAA, 1'b0);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: setting = '0;
				1: setting = 32'hFFFF_FFFF;
				2: setting = 32'h8000_0000;
				3: setting = $urandom;
				default: setting = tts_pkg::AUTO_PLAY_RESET;
			endcase
			write_auto_play(setting);
			if (phase == 4)
				quiet = 1'b1;
			target = ticks_queued + 306;
			while (ticks_queued < target) begin
				if ($urandom_range(0, 9) < 8) begin
					run_len = $urandom_range(40, 140);
					if (run_len >= target - ticks_queued)
						run_len = target - ticks_queued - 1;
					queue_melody_run(run_len);
				end else begin
					repeat ($urandom_range(1, 8)) queue_tick($urandom, $urandom_range(0, 3) == 0);
				end
			end
			if (phase == 1)
				hold_requests++;
		end

		wait_drained();
		repeat (5) @(posedge clk);
		if (tone_cmds_due.size() != 0) begin
			$error("%0d expected commands never arrived", tone_cmds_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
src/tts_pkg.sv
src/tts_if.sv
src/tts_note_rom.sv
src/timed_tone_sequencer.sv
bench/timed_tone_sequencer_test.sv
